@@ rtl/core/sfr_pkg.sv @@
// shared types and constants for the stream find-and-replace block
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int unsigned MAX_PATTERN_DEF     = 8;
	localparam int unsigned MAX_REPLACEMENT_DEF = 8;
	localparam int unsigned QUEUE_DEPTH         = 2;
	localparam int unsigned BYTE_W              = 8;
	localparam int unsigned LEN_W               = 4;
	localparam int unsigned CFG_INDEX_W         = 2;
	localparam int unsigned CFG_DATA_W          = 64;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                   write;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_write_t;

endpackage

@@ rtl/core/sfr_front.sv @@
// front end: configuration registers, match window and job classification
`timescale 1ns / 1ps

module sfr_front #(
	parameter int unsigned MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
	parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
	parameter int unsigned JOB_BYTES       = sfr_pkg::MAX_PATTERN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sfr_pkg::cfg_write_t                cfg,
	input  logic                               push,
	input  logic [sfr_pkg::BYTE_W-1:0]         in_byte,
	input  logic                               in_final,
	input  logic                               job_full,
	output logic                               job_push,
	output logic [JOB_BYTES-1:0][sfr_pkg::BYTE_W-1:0] job_bytes,
	output logic [$clog2(JOB_BYTES+1)-1:0]     job_count,
	output logic                               job_final
);

	localparam int unsigned WCNT_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned JCNT_W = $clog2(JOB_BYTES + 1);
	localparam int unsigned BW     = sfr_pkg::BYTE_W;
	localparam int unsigned LW     = sfr_pkg::LEN_W;

	logic [sfr_pkg::CFG_DATA_W-1:0] pattern_bytes_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] replacement_bytes_q;
	logic [LW-1:0]                  pattern_length_q;
	logic [LW-1:0]                  replacement_length_q;

	logic [MAX_PATTERN-1:0][BW-1:0] window_q;
	logic [MAX_PATTERN-1:0][BW-1:0] window_next;
	logic [MAX_PATTERN-1:0][BW-1:0] w_new;
	logic [WCNT_W-1:0]              count_q;
	logic [WCNT_W-1:0]              count_next;
	logic [WCNT_W-1:0]              cnt_inc;
	logic [WCNT_W-1:0]              plen;
	logic [JCNT_W-1:0]              rlen;
	logic                           match;
	logic                           complete;
	logic                           accept;
	logic                           plen_write;

	assign accept     = push && !job_full;
	assign job_push   = accept;
	assign job_final  = in_final;
	assign plen_write = cfg.write &&
		(sfr_pkg::cfg_reg_t'(cfg.index) == sfr_pkg::REG_PATTERN_LENGTH);

	always_comb begin
		plen = (pattern_length_q > LW'(MAX_PATTERN)) ? WCNT_W'(MAX_PATTERN)
			: WCNT_W'(pattern_length_q);
		rlen = (replacement_length_q > LW'(MAX_REPLACEMENT)) ? JCNT_W'(MAX_REPLACEMENT)
			: JCNT_W'(replacement_length_q);
		cnt_inc = count_q + WCNT_W'(1);

		// window with the incoming byte dropped into the next free slot
		for (int i = 0; i < MAX_PATTERN; i++) begin
			w_new[i] = (WCNT_W'(i) == count_q) ? in_byte : window_q[i];
		end

		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((WCNT_W'(i) < plen) && (w_new[i] != pattern_bytes_q[BW*i +: BW])) begin
				match = 1'b0;
			end
		end
		complete = (cnt_inc == plen);

		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			window_next[i] = complete ? w_new[i+1] : w_new[i];
		end
		window_next[MAX_PATTERN-1] = w_new[MAX_PATTERN-1];

		job_bytes  = '0;
		job_count  = '0;
		count_next = '0;
		if (plen == '0) begin
			// pass through
			job_bytes[0] = in_byte;
			job_count    = JCNT_W'(1);
		end else if (complete && match) begin
			for (int i = 0; i < MAX_REPLACEMENT; i++) begin
				job_bytes[i] = replacement_bytes_q[BW*i +: BW];
			end
			job_count = rlen;
		end else if (complete) begin
			// oldest byte leaves; on the final item the rest flushes behind it
			for (int i = 0; i < MAX_PATTERN; i++) begin
				job_bytes[i] = w_new[i];
			end
			job_count  = in_final ? JCNT_W'(plen) : JCNT_W'(1);
			count_next = in_final ? '0 : (plen - WCNT_W'(1));
		end else begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				job_bytes[i] = w_new[i];
			end
			job_count  = in_final ? JCNT_W'(cnt_inc) : '0;
			count_next = in_final ? '0 : cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= '0;
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
			count_q              <= '0;
		end else begin
			if (cfg.write) begin
				unique case (sfr_pkg::cfg_reg_t'(cfg.index))
					sfr_pkg::REG_PATTERN_BYTES: begin
						pattern_bytes_q <= cfg.data;
					end
					sfr_pkg::REG_PATTERN_LENGTH: begin
						pattern_length_q <= cfg.data[LW-1:0];
					end
					sfr_pkg::REG_REPLACEMENT_BYTES: begin
						replacement_bytes_q <= cfg.data;
					end
					sfr_pkg::REG_REPLACEMENT_LENGTH: begin
						replacement_length_q <= cfg.data[LW-1:0];
					end
					default: begin
					end
				endcase
			end
			if (plen_write) begin
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= window_next;
		end
	end

endmodule

@@ rtl/core/sfr_queue.sv @@
// small job queue between the front end and the output sequencer
`timescale 1ns / 1ps

module sfr_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             valid
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][WIDTH-1:0] slot_q;
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && valid;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/core/sfr_back.sv @@
// output sequencer: plays each job out one result per cycle into the output register unless the receiver stalls
`timescale 1ns / 1ps

module sfr_back #(
	parameter int unsigned JOB_BYTES = sfr_pkg::MAX_PATTERN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	input  logic [JOB_BYTES-1:0][sfr_pkg::BYTE_W-1:0] job_bytes,
	input  logic [$clog2(JOB_BYTES+1)-1:0]     job_count,
	input  logic                               job_final,
	output logic                               job_pop,
	output logic                               empty,
	input  logic                               pop,
	output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
	output logic                               has_byte,
	output logic                               run_end,
	output logic                               text_end
);

	localparam int unsigned JCNT_W = $clog2(JOB_BYTES + 1);
	localparam int unsigned BW     = sfr_pkg::BYTE_W;

	logic                           busy_q;
	logic [JOB_BYTES-1:0][BW-1:0]   rest_q;
	logic [JCNT_W-1:0]              rem_q;
	logic                           final_q;
	logic                           out_valid_q;
	logic [BW-1:0]                  out_byte_q;
	logic                           has_byte_q;
	logic                           run_end_q;
	logic                           text_end_q;

	logic                           out_free;
	logic                           emit;
	logic [JOB_BYTES-1:0][BW-1:0]   src;
	logic [JOB_BYTES-1:0][BW-1:0]   shifted;
	logic [BW-1:0]                  e_byte;
	logic                           e_has;
	logic                           e_last;
	logic                           e_final;
	logic [JCNT_W-1:0]              rem_next;

	assign out_free = !out_valid_q || pop;
	assign job_pop  = out_free && !busy_q && job_valid;
	assign emit     = out_free && (busy_q || job_valid);

	always_comb begin
		src = busy_q ? rest_q : job_bytes;
		for (int i = 0; i < JOB_BYTES - 1; i++) begin
			shifted[i] = src[i+1];
		end
		shifted[JOB_BYTES-1] = '0;

		if (busy_q) begin
			e_byte   = rest_q[0];
			e_has    = 1'b1;
			e_last   = (rem_q == JCNT_W'(1));
			e_final  = final_q;
			rem_next = rem_q - JCNT_W'(1);
		end else begin
			// a job with no bytes turns into a single marker
			e_has    = (job_count != '0);
			e_byte   = e_has ? job_bytes[0] : '0;
			e_last   = (job_count <= JCNT_W'(1));
			e_final  = job_final;
			rem_next = job_count - JCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q      <= !e_last;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rest_q     <= shifted;
			rem_q      <= rem_next;
			final_q    <= e_final;
			out_byte_q <= e_byte;
			has_byte_q <= e_has;
			run_end_q  <= e_last;
			text_end_q <= e_last && e_final;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign has_byte = has_byte_q;
	assign run_end  = run_end_q;
	assign text_end = text_end_q;

endmodule

@@ rtl/core/stream_find_replace.sv @@
// top level of the streaming find-and-replace block
// Usage: text enters one byte per item on the input queue (push/full), with in_final
// set on the last byte of a text. Results leave through the output queue (empty/pop):
// each carries out_byte with has_byte, run_end on the last result of its input item
// and text_end on the last result of the text. An item that yields no byte gives one
// marker result (has_byte low, run_end high).
// The search and replacement strings are set through cfg_write/cfg_index/cfg_data
// while the block is idle; writing the pattern length drops any pending window bytes.
// The job queue registers each accepted item, and the output register then holds its
// results. Throughput: one item per cycle while each item yields one result and pop
// stays high; an item with several results holds the output sequencer until all are out,
// and the two-entry job queue fills and raises full until the sequencer catches up.
// Reset clears the strings to empty (pass through), the window and both queues.
// When the receiver stalls (pop low) the output register holds its result, the job
// queue fills, and full rises; nothing is dropped.
`timescale 1ns / 1ps

module stream_find_replace #(
	parameter int unsigned MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
	parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [sfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               push,
	output logic                               full,
	input  logic [sfr_pkg::BYTE_W-1:0]         in_byte,
	input  logic                               in_final,
	output logic                               empty,
	input  logic                               pop,
	output logic [sfr_pkg::BYTE_W-1:0]         out_byte,
	output logic                               has_byte,
	output logic                               run_end,
	output logic                               text_end
);

	localparam int unsigned JOB_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
		: MAX_REPLACEMENT;
	localparam int unsigned JCNT_W    = $clog2(JOB_BYTES + 1);
	localparam int unsigned BW        = sfr_pkg::BYTE_W;
	localparam int unsigned JOB_W     = JOB_BYTES * BW + JCNT_W + 1;

	sfr_pkg::cfg_write_t          cfg;
	logic                         f_push;
	logic [JOB_BYTES-1:0][BW-1:0] f_bytes;
	logic [JCNT_W-1:0]            f_count;
	logic                         f_final;
	logic                         q_full;
	logic                         q_valid;
	logic                         q_pop;
	logic [JOB_W-1:0]             q_data;
	logic [JOB_BYTES-1:0][BW-1:0] b_bytes;
	logic [JCNT_W-1:0]            b_count;
	logic                         b_final;

	assign cfg.write = cfg_write;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;
	assign full      = q_full;

	sfr_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT),
		.JOB_BYTES       (JOB_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.in_byte   (in_byte),
		.in_final  (in_final),
		.job_full  (q_full),
		.job_push  (f_push),
		.job_bytes (f_bytes),
		.job_count (f_count),
		.job_final (f_final)
	);

	sfr_queue #(
		.WIDTH (JOB_W),
		.DEPTH (sfr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_push),
		.wr_data ({f_final, f_count, f_bytes}),
		.full    (q_full),
		.rd      (q_pop),
		.rd_data (q_data),
		.valid   (q_valid)
	);

	assign {b_final, b_count, b_bytes} = q_data;

	sfr_back #(
		.JOB_BYTES (JOB_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_bytes (b_bytes),
		.job_count (b_count),
		.job_final (b_final),
		.job_pop   (q_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.run_end   (run_end),
		.text_end  (text_end)
	);

endmodule
